// File: hdl/jvsd_pkg.sv
`default_nettype none

package jvsd_pkg;

	// Field widths fixed by the message set
	localparam int unsigned CAN_ID_W   = 29;
	localparam int unsigned DLC_W      = 4;
	localparam int unsigned DATA_W     = 64;
	localparam int unsigned PGN_W      = 17;
	localparam int unsigned VAL_W      = 16;
	localparam int unsigned RPM_W      = 13;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned TMO_W      = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned FLAG_W     = 5;

	// Known parameter group numbers
	localparam logic [PGN_W-1:0] PGN_ENGINE    = 17'h0F004;
	localparam logic [PGN_W-1:0] PGN_VEH_SPEED = 17'h0FEF1;
	localparam logic [PGN_W-1:0] PGN_SUPPLY    = 17'h0FEF7;

	// PF values from here up carry a group extension in PS
	localparam logic [7:0] PF_PDU2_MIN = 8'd240;

	localparam logic [DLC_W-1:0] MIN_DLC     = 4'd8;
	localparam logic [VAL_W-1:0] NOT_AVAIL16 = 16'hFFFF;
	localparam logic [VAL_W-1:0] MV_SAT      = 16'hFFFF;
	localparam logic [6:0]       MV_PER_BIT  = 7'd50;
	localparam logic [TIME_W-1:0] TICK_MS    = 32'd10;

	// Switch codes
	localparam logic [1:0] SW_OFF = 2'd0;
	localparam logic [1:0] SW_ON  = 2'd1;

	// Timeout register reset values
	localparam logic [TMO_W-1:0] SPEED_TMO_RST  = 16'd500;
	localparam logic [TMO_W-1:0] ENGINE_TMO_RST = 16'd500;
	localparam logic [TMO_W-1:0] SUPPLY_TMO_RST = 16'd1000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_TMO  = 2'd0,
		REG_ENGINE_TMO = 2'd1,
		REG_SUPPLY_TMO = 2'd2
	} jvsd_reg_t;

	// Valid flag bit positions
	localparam int unsigned V_SPEED  = 0;
	localparam int unsigned V_RPM    = 1;
	localparam int unsigned V_PARK   = 2;
	localparam int unsigned V_BRAKE  = 3;
	localparam int unsigned V_SUPPLY = 4;

	// Request kinds
	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TICK,
		OP_CCVS,
		OP_EEC1,
		OP_VEP1
	} jvsd_kind_t;

	typedef struct packed {
		logic                cmd;
		logic [CAN_ID_W-1:0] can_id;
		logic [DLC_W-1:0]    frame_len;
		logic [DATA_W-1:0]   payload;
	} jvsd_in_t;

	typedef struct packed {
		logic [VAL_W-1:0] wheel_speed;
		logic             speed_ok;
		logic [RPM_W-1:0] engine_rpm;
		logic             engine_rpm_ok;
		logic             park_brake_on;
		logic             park_brake_ok;
		logic             brake_pedal_on;
		logic             brake_pedal_ok;
		logic [VAL_W-1:0] key_supply_mv;
		logic             key_supply_ok;
	} jvsd_out_t;

	// val holds speed raw, rpm (low bits) or scaled supply, by kind
	typedef struct packed {
		jvsd_kind_t       kind;
		logic [VAL_W-1:0] val;
		logic             val_na;
		logic [1:0]       park_code;
		logic [1:0]       brake_code;
	} jvsd_op_t;

endpackage

`default_nettype wire

// File: hdl/jvsd_fifo.sv
`default_nettype none

module jvsd_fifo #(
	parameter type         T     = logic,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire T     wr_data,
	output logic      full,
	input  wire logic rd_en,
	output T          rd_data,
	output logic      empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	T                mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/jvsd_front.sv
`default_nettype none

module jvsd_front (
	input  wire jvsd_pkg::jvsd_in_t req,
	output jvsd_pkg::jvsd_op_t      op
);

	logic [7:0]                    pf;
	logic [7:0]                    ps;
	logic [jvsd_pkg::PGN_W-1:0]    pgn;
	logic                          long_enough;
	logic [jvsd_pkg::VAL_W-1:0]    speed_raw;
	logic [jvsd_pkg::VAL_W-1:0]    rpm_raw;
	logic [jvsd_pkg::VAL_W-1:0]    supply_raw;
	logic [jvsd_pkg::VAL_W+6:0]    mv_full;
	logic [jvsd_pkg::VAL_W-1:0]    mv_sat;

	// PGN: PS only counts for PDU2 formats
	assign pf  = req.can_id[23:16];
	assign ps  = req.can_id[15:8];
	assign pgn = {req.can_id[24], pf, (pf >= jvsd_pkg::PF_PDU2_MIN) ? ps : 8'h00};
	assign long_enough = (req.frame_len >= jvsd_pkg::MIN_DLC);

	// raw little-endian words
	assign speed_raw  = req.payload[23:8];
	assign rpm_raw    = req.payload[39:24];
	assign supply_raw = req.payload[63:48];

	// supply scaling, 50 mV per bit, saturated
	assign mv_full = {7'd0, supply_raw} * {16'd0, jvsd_pkg::MV_PER_BIT};
	assign mv_sat  = (mv_full[jvsd_pkg::VAL_W+6:jvsd_pkg::VAL_W] != '0) ?
		jvsd_pkg::MV_SAT : mv_full[jvsd_pkg::VAL_W-1:0];

	// classify
	always_comb begin
		op            = '0;
		op.kind       = jvsd_pkg::OP_NONE;
		op.park_code  = req.payload[3:2];
		op.brake_code = req.payload[29:28];
		if (req.cmd == jvsd_pkg::CMD_TICK) begin
			op.kind = jvsd_pkg::OP_TICK;
		end else if (long_enough) begin
			priority if (pgn == jvsd_pkg::PGN_VEH_SPEED) begin
				op.kind   = jvsd_pkg::OP_CCVS;
				op.val    = speed_raw;
				op.val_na = (speed_raw == jvsd_pkg::NOT_AVAIL16);
			end else if (pgn == jvsd_pkg::PGN_ENGINE) begin
				op.kind   = jvsd_pkg::OP_EEC1;
				op.val    = {3'd0, rpm_raw[15:3]};
				op.val_na = (rpm_raw == jvsd_pkg::NOT_AVAIL16);
			end else if (pgn == jvsd_pkg::PGN_SUPPLY) begin
				op.kind   = jvsd_pkg::OP_VEP1;
				op.val    = mv_sat;
				op.val_na = (supply_raw == jvsd_pkg::NOT_AVAIL16);
			end else begin
				op.kind = jvsd_pkg::OP_NONE;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/jvsd_back.sv
`default_nettype none

module jvsd_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire jvsd_pkg::jvsd_op_t                op,
	input  wire logic                              op_valid,
	output logic                                   op_pop,
	input  wire logic                              res_full,
	output logic                                   res_push,
	output jvsd_pkg::jvsd_out_t                    res,
	input  wire logic                              cfg_valid,
	input  wire logic [jvsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [jvsd_pkg::TMO_W-1:0]        cfg_data
);

	localparam int unsigned TW = jvsd_pkg::TIME_W;

	logic [jvsd_pkg::TMO_W-1:0]  speed_tmo_q, engine_tmo_q, supply_tmo_q;
	logic [TW-1:0]               clock_q, clock_nxt_q;
	logic [TW-1:0]               speed_seen_q, engine_seen_q, supply_seen_q;
	logic [jvsd_pkg::VAL_W-1:0]  speed_q, supply_q;
	logic [jvsd_pkg::RPM_W-1:0]  rpm_q;
	logic [1:0]                  sw_q;
	logic [jvsd_pkg::FLAG_W-1:0] flags_q;

	logic [TW-1:0]               clock_d, clock_nxt_d;
	logic [TW-1:0]               speed_seen_d, engine_seen_d, supply_seen_d;
	logic [jvsd_pkg::VAL_W-1:0]  speed_d, supply_d;
	logic [jvsd_pkg::RPM_W-1:0]  rpm_d;
	logic [1:0]                  sw_d;
	logic [jvsd_pkg::FLAG_W-1:0] flags_d;

	logic fire;
	logic speed_late, engine_late, supply_late;

	assign fire     = op_valid && !res_full;
	assign op_pop   = fire;
	assign res_push = fire;

	// group ages at the time after this tick
	assign speed_late  = (clock_nxt_q - speed_seen_q)  > {16'd0, speed_tmo_q};
	assign engine_late = (clock_nxt_q - engine_seen_q) > {16'd0, engine_tmo_q};
	assign supply_late = (clock_nxt_q - supply_seen_q) > {16'd0, supply_tmo_q};

	// next state
	always_comb begin
		clock_d       = clock_q;
		clock_nxt_d   = clock_nxt_q;
		speed_seen_d  = speed_seen_q;
		engine_seen_d = engine_seen_q;
		supply_seen_d = supply_seen_q;
		speed_d       = speed_q;
		rpm_d         = rpm_q;
		supply_d      = supply_q;
		sw_d          = sw_q;
		flags_d       = flags_q;
		if (fire) begin
			unique case (op.kind)
				jvsd_pkg::OP_TICK: begin
					clock_d     = clock_nxt_q;
					clock_nxt_d = clock_nxt_q + jvsd_pkg::TICK_MS;
					if (speed_late) begin
						flags_d[jvsd_pkg::V_SPEED] = 1'b0;
						flags_d[jvsd_pkg::V_PARK]  = 1'b0;
						flags_d[jvsd_pkg::V_BRAKE] = 1'b0;
					end
					if (engine_late) begin
						flags_d[jvsd_pkg::V_RPM] = 1'b0;
					end
					if (supply_late) begin
						flags_d[jvsd_pkg::V_SUPPLY] = 1'b0;
					end
				end
				jvsd_pkg::OP_CCVS: begin
					unique case (op.park_code)
						jvsd_pkg::SW_OFF: begin
							sw_d[0] = 1'b0;
							flags_d[jvsd_pkg::V_PARK] = 1'b1;
						end
						jvsd_pkg::SW_ON: begin
							sw_d[0] = 1'b1;
							flags_d[jvsd_pkg::V_PARK] = 1'b1;
						end
						default: flags_d[jvsd_pkg::V_PARK] = 1'b0;
					endcase
					unique case (op.brake_code)
						jvsd_pkg::SW_OFF: begin
							sw_d[1] = 1'b0;
							flags_d[jvsd_pkg::V_BRAKE] = 1'b1;
						end
						jvsd_pkg::SW_ON: begin
							sw_d[1] = 1'b1;
							flags_d[jvsd_pkg::V_BRAKE] = 1'b1;
						end
						default: flags_d[jvsd_pkg::V_BRAKE] = 1'b0;
					endcase
					if (!op.val_na) begin
						speed_d = op.val;
					end
					flags_d[jvsd_pkg::V_SPEED] = !op.val_na;
					speed_seen_d = clock_q;
				end
				jvsd_pkg::OP_EEC1: begin
					if (!op.val_na) begin
						rpm_d = op.val[jvsd_pkg::RPM_W-1:0];
					end
					flags_d[jvsd_pkg::V_RPM] = !op.val_na;
					engine_seen_d = clock_q;
				end
				jvsd_pkg::OP_VEP1: begin
					if (!op.val_na) begin
						supply_d = op.val;
					end
					flags_d[jvsd_pkg::V_SUPPLY] = !op.val_na;
					supply_seen_d = clock_q;
				end
				default: begin
				end
			endcase
		end
	end

	// snapshot of the updated state
	always_comb begin
		res.wheel_speed    = speed_d;
		res.speed_ok       = flags_d[jvsd_pkg::V_SPEED];
		res.engine_rpm     = rpm_d;
		res.engine_rpm_ok  = flags_d[jvsd_pkg::V_RPM];
		res.park_brake_on  = sw_d[0];
		res.park_brake_ok  = flags_d[jvsd_pkg::V_PARK];
		res.brake_pedal_on = sw_d[1];
		res.brake_pedal_ok = flags_d[jvsd_pkg::V_BRAKE];
		res.key_supply_mv  = supply_d;
		res.key_supply_ok  = flags_d[jvsd_pkg::V_SUPPLY];
	end

	// timeout registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_tmo_q  <= jvsd_pkg::SPEED_TMO_RST;
			engine_tmo_q <= jvsd_pkg::ENGINE_TMO_RST;
			supply_tmo_q <= jvsd_pkg::SUPPLY_TMO_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jvsd_pkg::REG_SPEED_TMO:  speed_tmo_q  <= cfg_data;
				jvsd_pkg::REG_ENGINE_TMO: engine_tmo_q <= cfg_data;
				jvsd_pkg::REG_SUPPLY_TMO: supply_tmo_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q       <= '0;
			clock_nxt_q   <= jvsd_pkg::TICK_MS;
			speed_seen_q  <= '0;
			engine_seen_q <= '0;
			supply_seen_q <= '0;
			speed_q       <= '0;
			rpm_q         <= '0;
			supply_q      <= '0;
			sw_q          <= '0;
			flags_q       <= '0;
		end else begin
			clock_q       <= clock_d;
			clock_nxt_q   <= clock_nxt_d;
			speed_seen_q  <= speed_seen_d;
			engine_seen_q <= engine_seen_d;
			supply_seen_q <= supply_seen_d;
			speed_q       <= speed_d;
			rpm_q         <= rpm_d;
			supply_q      <= supply_d;
			sw_q          <= sw_d;
			flags_q       <= flags_d;
		end
	end

	// look-ahead time always one tick ahead
	a_clock_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		clock_nxt_q == clock_q + jvsd_pkg::TICK_MS)
		else $error("look-ahead clock out of step");

	// frames never move time
	a_frame_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op.kind != jvsd_pkg::OP_TICK |=> $stable(clock_q))
		else $error("frame advanced the clock");

	// ticks only ever clear valid flags
	a_tick_no_set: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op.kind == jvsd_pkg::OP_TICK |=> (flags_q & ~$past(flags_q)) == '0)
		else $error("tick set a valid flag");

	// ignored frames leave flags alone
	a_none_stable: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op.kind == jvsd_pkg::OP_NONE |=> $stable(flags_q))
		else $error("ignored frame changed flags");

endmodule

`default_nettype wire

// File: hdl/j1939_vehicle_signal_decoder_core.sv
`default_nettype none
// J1939 vehicle signal decoder.
// Input channel (push/full): each request is either a received extended CAN
// frame (cmd = 0) or one 10 ms time tick (cmd = 1). Frames of CCVS, EEC1 and
// VEP1 with a DLC of 8 or more update the held signals and stamp their group.
// Result channel (empty/pop): exactly one snapshot of all held values and
// valid flags per request, in request order.
// Configuration channel (cfg_valid/cfg_ready): three 16-bit group timeouts in
// ms; the user must write them only while the block is idle, as the block
// does not enforce this. cfg_ready is always high. A request is decoded
// combinationally into the command queue; the back end writes its snapshot
// into the result queue and empty falls. Throughput: one request per cycle
// while the result queue has room, limited by the single back-end update step.
// When the receiver stalls, the result queue fills, the back end holds, the
// command queue fills behind it and full rises; nothing is dropped.
// Reset: all held values, times and valid flags clear, timeouts return to
// 500/500/1000 ms and both queues empty.
module j1939_vehicle_signal_decoder_core #(
	parameter int unsigned CMD_QUEUE_DEPTH = 2,
	parameter int unsigned RES_QUEUE_DEPTH = 2
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire jvsd_pkg::jvsd_in_t                req,
	output logic                                   empty,
	input  wire logic                              pop,
	output jvsd_pkg::jvsd_out_t                    rsp,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [jvsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [jvsd_pkg::TMO_W-1:0]        cfg_data
);

	jvsd_pkg::jvsd_op_t  op_in, op_out;
	jvsd_pkg::jvsd_out_t res;
	logic                op_empty, op_pop, res_full, res_push;

	assign cfg_ready = 1'b1;

	// classify incoming requests
	jvsd_front u_front (
		.req (req),
		.op  (op_in)
	);

	// command queue between front and back
	jvsd_fifo #(
		.T     (jvsd_pkg::jvsd_op_t),
		.DEPTH (CMD_QUEUE_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (op_in),
		.full    (full),
		.rd_en   (op_pop),
		.rd_data (op_out),
		.empty   (op_empty)
	);

	// state update and snapshot
	jvsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op_out),
		.op_valid  (!op_empty),
		.op_pop    (op_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// result queue
	jvsd_fifo #(
		.T     (jvsd_pkg::jvsd_out_t),
		.DEPTH (RES_QUEUE_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (rsp),
		.empty   (empty)
	);

endmodule

`default_nettype wire

// File: test/j1939_vehicle_signal_decoder_core_tb.sv
// Tracks what the decoder should report: it keeps its own copy of the held
// signals, group time stamps and timeouts, and queues one snapshot per request.
class signal_scoreboard;
	jvsd_pkg::jvsd_out_t pending_snapshots[$];
	int unsigned mismatches;

	logic [jvsd_pkg::TMO_W-1:0]  tmo_speed, tmo_engine, tmo_supply;
	logic [jvsd_pkg::TIME_W-1:0] now_ms, speed_seen_ms, engine_seen_ms, supply_seen_ms;
	logic [jvsd_pkg::VAL_W-1:0]  last_speed, last_supply_mv;
	logic [jvsd_pkg::RPM_W-1:0]  last_rpm;
	logic                        last_park, last_brake;
	logic [jvsd_pkg::FLAG_W-1:0] ok_flags;

	function new();
		mismatches     = 0;
		tmo_speed      = jvsd_pkg::SPEED_TMO_RST;
		tmo_engine     = jvsd_pkg::ENGINE_TMO_RST;
		tmo_supply     = jvsd_pkg::SUPPLY_TMO_RST;
		now_ms         = '0;
		speed_seen_ms  = '0;
		engine_seen_ms = '0;
		supply_seen_ms = '0;
		last_speed     = '0;
		last_supply_mv = '0;
		last_rpm       = '0;
		last_park      = 1'b0;
		last_brake     = 1'b0;
		ok_flags       = '0;
	endfunction

	// Unknown indexes fall through and change nothing
	function void write_register(logic [jvsd_pkg::CFG_IDX_W-1:0] idx,
			logic [jvsd_pkg::TMO_W-1:0] data);
		case (idx)
		jvsd_pkg::REG_SPEED_TMO:  tmo_speed = data;
		jvsd_pkg::REG_ENGINE_TMO: tmo_engine = data;
		jvsd_pkg::REG_SUPPLY_TMO: tmo_supply = data;
		default: ;
		endcase
	endfunction

	// One 10 ms tick: ages wrap modulo 2^32, expiry only when strictly older
	function void advance_clock();
		now_ms = now_ms + jvsd_pkg::TICK_MS;
		if (now_ms - speed_seen_ms > jvsd_pkg::TIME_W'(tmo_speed)) begin
			ok_flags[jvsd_pkg::V_SPEED] = 1'b0;
			ok_flags[jvsd_pkg::V_PARK]  = 1'b0;
			ok_flags[jvsd_pkg::V_BRAKE] = 1'b0;
		end
		if (now_ms - engine_seen_ms > jvsd_pkg::TIME_W'(tmo_engine))
			ok_flags[jvsd_pkg::V_RPM] = 1'b0;
		if (now_ms - supply_seen_ms > jvsd_pkg::TIME_W'(tmo_supply))
			ok_flags[jvsd_pkg::V_SUPPLY] = 1'b0;
	endfunction

	function void decode_frame(jvsd_pkg::jvsd_in_t r);
		logic [7:0]                 pf;
		logic [jvsd_pkg::PGN_W-1:0] pgn;
		logic [jvsd_pkg::VAL_W-1:0] raw;
		logic [1:0]                 park, brake;
		logic [31:0]                mv;
		pf  = r.can_id[23:16];
		pgn = {r.can_id[24], pf, 8'h00};
		// group extension only counts for PDU2 format
		if (pf >= jvsd_pkg::PF_PDU2_MIN)
			pgn[7:0] = r.can_id[15:8];
		// short frames leave even the time stamp alone
		if (r.frame_len < jvsd_pkg::MIN_DLC)
			return;
		case (pgn)
		jvsd_pkg::PGN_VEH_SPEED: begin
			park  = r.payload[3:2];
			brake = r.payload[29:28];
			raw   = r.payload[23:8];
			if (park == jvsd_pkg::SW_OFF || park == jvsd_pkg::SW_ON) begin
				last_park                  = park[0];
				ok_flags[jvsd_pkg::V_PARK] = 1'b1;
			end else
				ok_flags[jvsd_pkg::V_PARK] = 1'b0;
			if (brake == jvsd_pkg::SW_OFF || brake == jvsd_pkg::SW_ON) begin
				last_brake                  = brake[0];
				ok_flags[jvsd_pkg::V_BRAKE] = 1'b1;
			end else
				ok_flags[jvsd_pkg::V_BRAKE] = 1'b0;
			if (raw != jvsd_pkg::NOT_AVAIL16) begin
				last_speed                  = raw;
				ok_flags[jvsd_pkg::V_SPEED] = 1'b1;
			end else
				ok_flags[jvsd_pkg::V_SPEED] = 1'b0;
			speed_seen_ms = now_ms;
		end
		jvsd_pkg::PGN_ENGINE: begin
			raw = r.payload[39:24];
			if (raw != jvsd_pkg::NOT_AVAIL16) begin
				last_rpm                  = raw[15:3];
				ok_flags[jvsd_pkg::V_RPM] = 1'b1;
			end else
				ok_flags[jvsd_pkg::V_RPM] = 1'b0;
			engine_seen_ms = now_ms;
		end
		jvsd_pkg::PGN_SUPPLY: begin
			raw = r.payload[63:48];
			if (raw != jvsd_pkg::NOT_AVAIL16) begin
				mv             = 32'(raw) * 32'(jvsd_pkg::MV_PER_BIT);
				last_supply_mv = (mv > 32'(jvsd_pkg::MV_SAT)) ? jvsd_pkg::MV_SAT : mv[15:0];
				ok_flags[jvsd_pkg::V_SUPPLY] = 1'b1;
			end else
				ok_flags[jvsd_pkg::V_SUPPLY] = 1'b0;
			supply_seen_ms = now_ms;
		end
		default: ;
		endcase
	endfunction

	function void note_request(jvsd_pkg::jvsd_in_t r);
		jvsd_pkg::jvsd_out_t snap;
		if (r.cmd == jvsd_pkg::CMD_TICK)
			advance_clock();
		else
			decode_frame(r);
		snap.wheel_speed    = last_speed;
		snap.speed_ok       = ok_flags[jvsd_pkg::V_SPEED];
		snap.engine_rpm     = last_rpm;
		snap.engine_rpm_ok  = ok_flags[jvsd_pkg::V_RPM];
		snap.park_brake_on  = last_park;
		snap.park_brake_ok  = ok_flags[jvsd_pkg::V_PARK];
		snap.brake_pedal_on = last_brake;
		snap.brake_pedal_ok = ok_flags[jvsd_pkg::V_BRAKE];
		snap.key_supply_mv  = last_supply_mv;
		snap.key_supply_ok  = ok_flags[jvsd_pkg::V_SUPPLY];
		pending_snapshots.push_back(snap);
	endfunction

	function void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	function void check_snapshot(jvsd_pkg::jvsd_out_t got);
		jvsd_pkg::jvsd_out_t want;
		if (pending_snapshots.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("snapshot with no request outstanding: %h", got);
			return;
		end
		want = pending_snapshots.pop_front();
		compare_field("wheel_speed", want.wheel_speed, got.wheel_speed);
		compare_field("speed_ok", 16'(want.speed_ok), 16'(got.speed_ok));
		compare_field("engine_rpm", 16'(want.engine_rpm), 16'(got.engine_rpm));
		compare_field("engine_rpm_ok", 16'(want.engine_rpm_ok), 16'(got.engine_rpm_ok));
		compare_field("park_brake_on", 16'(want.park_brake_on), 16'(got.park_brake_on));
		compare_field("park_brake_ok", 16'(want.park_brake_ok), 16'(got.park_brake_ok));
		compare_field("brake_pedal_on", 16'(want.brake_pedal_on),
			16'(got.brake_pedal_on));
		compare_field("brake_pedal_ok", 16'(want.brake_pedal_ok),
			16'(got.brake_pedal_ok));
		compare_field("key_supply_mv", want.key_supply_mv, got.key_supply_mv);
		compare_field("key_supply_ok", 16'(want.key_supply_ok), 16'(got.key_supply_ok));
	endfunction
endclass

module j1939_vehicle_signal_decoder_core_tb;

	localparam int unsigned                    CYCLE_LIMIT     = 200000;
	localparam int unsigned                    HOLD_OFF_CYCLES = 80;
	localparam logic [jvsd_pkg::CFG_IDX_W-1:0] REG_UNUSED      = 2'd3;
	localparam logic [1:0]                     SW_ERROR        = 2'd2;
	localparam logic [1:0]                     SW_NA           = 2'd3;
	localparam logic [jvsd_pkg::PGN_W-1:0]     DATA_PAGE       = 17'h10000;
	// PF below 240 with a PS equal to the low byte of the speed group number
	localparam logic [jvsd_pkg::PGN_W-1:0]     PDU1_LOOKALIKE  = 17'h0EFF1;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	jvsd_pkg::jvsd_in_t             req;
	logic                           empty;
	logic                           pop;
	jvsd_pkg::jvsd_out_t            rsp;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [jvsd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [jvsd_pkg::TMO_W-1:0]     cfg_data;

	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_req = 1'b0;

	signal_scoreboard sb = new();

	j1939_vehicle_signal_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests, snapshots and register writes as seen at the clock edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_register(cfg_index, cfg_data);
			if (push && !full)
				sb.note_request(req);
			if (pop && !empty)
				sb.check_snapshot(rsp);
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			pop <= rx_gaps ? ($urandom_range(99) >= 21) : 1'b1;
		end
	end

	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [jvsd_pkg::DATA_W-1:0] ccvs_data(logic [1:0] park,
			logic [1:0] brake, logic [jvsd_pkg::VAL_W-1:0] speed);
		logic [jvsd_pkg::DATA_W-1:0] p;
		p        = {$urandom, $urandom};
		p[3:2]   = park;
		p[29:28] = brake;
		p[23:8]  = speed;
		return p;
	endfunction

	function automatic logic [jvsd_pkg::DATA_W-1:0] eec1_data(
			logic [jvsd_pkg::VAL_W-1:0] raw);
		logic [jvsd_pkg::DATA_W-1:0] p;
		p        = {$urandom, $urandom};
		p[39:24] = raw;
		return p;
	endfunction

	function automatic logic [jvsd_pkg::DATA_W-1:0] vep1_data(
			logic [jvsd_pkg::VAL_W-1:0] raw);
		logic [jvsd_pkg::DATA_W-1:0] p;
		p        = {$urandom, $urandom};
		p[63:48] = raw;
		return p;
	endfunction

	// Mostly usable codes, half the supply words from 0 to 1400, some not-available words
	function automatic logic [jvsd_pkg::DATA_W-1:0] random_payload();
		logic [jvsd_pkg::DATA_W-1:0] p;
		p = {$urandom, $urandom};
		if ($urandom_range(3) != 0)
			p[3] = 1'b0;
		if ($urandom_range(3) != 0)
			p[29] = 1'b0;
		if ($urandom_range(1) != 0)
			p[63:48] = jvsd_pkg::VAL_W'($urandom_range(0, 1400));
		if ($urandom_range(7) == 0)
			p[23:8] = jvsd_pkg::NOT_AVAIL16;
		if ($urandom_range(7) == 0)
			p[39:24] = jvsd_pkg::NOT_AVAIL16;
		if ($urandom_range(7) == 0)
			p[63:48] = jvsd_pkg::NOT_AVAIL16;
		return p;
	endfunction

	// Priority, reserved bit and source address stay random
	function automatic jvsd_pkg::jvsd_in_t frame_request(logic [jvsd_pkg::PGN_W-1:0] pgn,
			logic [jvsd_pkg::DLC_W-1:0] len, logic [jvsd_pkg::DATA_W-1:0] data);
		jvsd_pkg::jvsd_in_t r;
		r.cmd          = jvsd_pkg::CMD_FRAME;
		r.can_id       = jvsd_pkg::CAN_ID_W'($urandom);
		r.can_id[24:8] = pgn;
		r.frame_len    = len;
		r.payload      = data;
		return r;
	endfunction

	function automatic jvsd_pkg::jvsd_in_t tick_request();
		jvsd_pkg::jvsd_in_t r;
		r.cmd       = jvsd_pkg::CMD_TICK;
		r.can_id    = jvsd_pkg::CAN_ID_W'($urandom);
		r.frame_len = jvsd_pkg::DLC_W'($urandom);
		r.payload   = {$urandom, $urandom};
		return r;
	endfunction

	function automatic jvsd_pkg::jvsd_in_t random_request(int unsigned tick_pct);
		int unsigned                pick;
		logic [jvsd_pkg::PGN_W-1:0] pgn;
		jvsd_pkg::jvsd_in_t         r;
		if ($urandom_range(99) < tick_pct)
			return tick_request();
		pick = $urandom_range(99);
		pgn  = (pick < 33) ? jvsd_pkg::PGN_VEH_SPEED :
			(pick < 66) ? jvsd_pkg::PGN_ENGINE : jvsd_pkg::PGN_SUPPLY;
		pick = $urandom_range(99);
		if (pick < 80)
			return frame_request(pgn, jvsd_pkg::DLC_W'($urandom_range(8, 15)),
				random_payload());
		if (pick < 90)
			return frame_request(pgn, jvsd_pkg::DLC_W'($urandom_range(0, 7)),
				random_payload());
		// anything at all, nearly always an unknown group
		r.cmd       = jvsd_pkg::CMD_FRAME;
		r.can_id    = jvsd_pkg::CAN_ID_W'($urandom);
		r.frame_len = jvsd_pkg::DLC_W'($urandom);
		r.payload   = {$urandom, $urandom};
		return r;
	endfunction

	// push is left high after acceptance so back-to-back requests need no toggle
	task automatic send_request(input jvsd_pkg::jvsd_in_t r);
		if (tx_gaps && $urandom_range(99) < 21) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		push <= 1'b1;
		req  <= r;
		do @(posedge clk); while (full);
	endtask

	task automatic wait_for_snapshots();
		push <= 1'b0;
		do @(posedge clk); while (sb.pending_snapshots.size() != 0);
	endtask

	// Writes only once the block has drained
	task automatic program_timeouts(input logic [jvsd_pkg::TMO_W-1:0] t_speed, t_engine,
			t_supply, input bit poke_unused);
		logic [jvsd_pkg::CFG_IDX_W-1:0] regs [4];
		logic [jvsd_pkg::TMO_W-1:0]     vals [4];
		regs = '{jvsd_pkg::REG_SPEED_TMO, jvsd_pkg::REG_ENGINE_TMO,
			jvsd_pkg::REG_SUPPLY_TMO, REG_UNUSED};
		vals = '{t_speed, t_engine, t_supply, jvsd_pkg::TMO_W'($urandom)};
		wait_for_snapshots();
		for (int k = 0; k < (poke_unused ? 4 : 3); k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[k];
			cfg_data  <= vals[k];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int unsigned count, input int unsigned tick_pct);
		repeat (count) send_request(random_request(tick_pct));
	endtask

	initial begin
		arst_n    <= 1'b0;
		push      <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, not-available values, saturation
		send_request(tick_request());
		send_request(frame_request(jvsd_pkg::PGN_VEH_SPEED, jvsd_pkg::MIN_DLC,
			ccvs_data(jvsd_pkg::SW_OFF, jvsd_pkg::SW_ON, 16'h0000)));
		send_request(frame_request(jvsd_pkg::PGN_VEH_SPEED, 4'hF,
			ccvs_data(jvsd_pkg::SW_ON, jvsd_pkg::SW_OFF, 16'hFFFE)));
		send_request(frame_request(jvsd_pkg::PGN_VEH_SPEED, jvsd_pkg::MIN_DLC,
			ccvs_data(SW_ERROR, SW_NA, jvsd_pkg::NOT_AVAIL16)));
		send_request(frame_request(jvsd_pkg::PGN_ENGINE, jvsd_pkg::MIN_DLC,
			eec1_data(16'h0000)));
		send_request(frame_request(jvsd_pkg::PGN_ENGINE, 4'hF, eec1_data(16'hFFFE)));
		send_request(frame_request(jvsd_pkg::PGN_ENGINE, jvsd_pkg::MIN_DLC,
			eec1_data(jvsd_pkg::NOT_AVAIL16)));
		send_request(frame_request(jvsd_pkg::PGN_SUPPLY, jvsd_pkg::MIN_DLC,
			vep1_data(16'd1310)));
		send_request(frame_request(jvsd_pkg::PGN_SUPPLY, jvsd_pkg::MIN_DLC,
			vep1_data(16'd1311)));
		send_request(frame_request(jvsd_pkg::PGN_SUPPLY, jvsd_pkg::MIN_DLC,
			vep1_data(jvsd_pkg::NOT_AVAIL16)));
		send_request(frame_request(jvsd_pkg::PGN_SUPPLY, 4'hC, vep1_data(16'h0000)));
		// short frames of known groups
		send_request(frame_request(jvsd_pkg::PGN_VEH_SPEED, 4'd7,
			ccvs_data(jvsd_pkg::SW_ON, jvsd_pkg::SW_ON, 16'h1234)));
		send_request(frame_request(jvsd_pkg::PGN_ENGINE, 4'd0, eec1_data(16'h4000)));
		// near misses on the group number
		send_request(frame_request(jvsd_pkg::PGN_VEH_SPEED | DATA_PAGE, jvsd_pkg::MIN_DLC,
			ccvs_data(jvsd_pkg::SW_ON, jvsd_pkg::SW_ON, 16'h0101)));
		send_request(frame_request(PDU1_LOOKALIKE, jvsd_pkg::MIN_DLC,
			ccvs_data(jvsd_pkg::SW_ON, jvsd_pkg::SW_ON, 16'h0202)));
		send_request(jvsd_pkg::jvsd_in_t'{cmd: jvsd_pkg::CMD_FRAME, can_id: '1,
			frame_len: '1, payload: '1});
		send_request(jvsd_pkg::jvsd_in_t'{cmd: jvsd_pkg::CMD_FRAME, can_id: '0,
			frame_len: '0, payload: '0});
		send_request(jvsd_pkg::jvsd_in_t'{cmd: jvsd_pkg::CMD_TICK, can_id: '1,
			frame_len: '1, payload: '1});

		// timeout edges: engine goes at the first tick, speed after 30 ms, supply after 40
		program_timeouts(16'd20, 16'd0, 16'd30, 1'b1);
		send_request(frame_request(jvsd_pkg::PGN_VEH_SPEED, jvsd_pkg::MIN_DLC,
			ccvs_data(jvsd_pkg::SW_ON, jvsd_pkg::SW_ON, 16'h5000)));
		send_request(frame_request(jvsd_pkg::PGN_ENGINE, jvsd_pkg::MIN_DLC,
			eec1_data(16'h2EE0)));
		send_request(frame_request(jvsd_pkg::PGN_SUPPLY, jvsd_pkg::MIN_DLC,
			vep1_data(16'd480)));
		repeat (4) send_request(tick_request());

		// random phases over several timeout settings
		run_random(100, 35);
		program_timeouts(16'd0, 16'd0, 16'd0, 1'b1);
		run_random(60, 30);
		program_timeouts(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		run_random(60, 50);

		// a stretch with neither side idling
		program_timeouts(jvsd_pkg::TMO_W'($urandom_range(0, 200)),
			jvsd_pkg::TMO_W'($urandom_range(0, 200)),
			jvsd_pkg::TMO_W'($urandom_range(0, 200)), 1'b0);
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		run_random(60, 40);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;

		// receiver holds off while requests keep coming, so full must rise
		program_timeouts(16'd30, 16'd60, 16'd10, 1'b1);
		hold_req = 1'b1;
		run_random(50, 40);

		program_timeouts(jvsd_pkg::SPEED_TMO_RST, jvsd_pkg::ENGINE_TMO_RST,
			jvsd_pkg::SUPPLY_TMO_RST, 1'b0);
		run_random(110, 60);

		wait_for_snapshots();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_snapshots.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
